### design/bth_pkg.sv
// Shared types, codes and helpers for the boundary-tag heap allocator.
`default_nettype none

package bth_pkg;

    localparam int BTH_HEAP_WORDS = 1024;

    // Signed heap positions, wide enough for a tag's room added to any index.
    localparam int POS_W = 34;
    typedef logic signed [POS_W-1:0] pos_t;

    localparam logic [3:0] CMD_ALLOC        = 4'd0;
    localparam logic [3:0] CMD_ALLOC_ZEROED = 4'd1;
    localparam logic [3:0] CMD_RESIZE       = 4'd2;
    localparam logic [3:0] CMD_RELEASE      = 4'd3;
    localparam logic [3:0] CMD_CHECK        = 4'd4;
    localparam logic [3:0] CMD_STATS        = 4'd5;
    localparam logic [3:0] CMD_READ_WORD    = 4'd6;
    localparam logic [3:0] CMD_WRITE_WORD   = 4'd7;
    localparam logic [3:0] CMD_REINIT       = 4'd8;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_RANGE   = 2'd2,
        ST_CORRUPT = 2'd3
    } status_t;

    typedef enum logic [5:0] {
        OP_NOP, OP_LOAD, OP_INIT0, OP_INIT1, OP_START,
        OP_RD_H, OP_RD_IDXM1, OP_RD_T, OP_RD_HM1, OP_RD_U, OP_RD_LS, OP_RD_START,
        OP_RD_IDX, OP_CAP_OLDR, OP_CP_READ,
        OP_WR_H_WORDS, OP_WR_SPL1, OP_WR_SPL2, OP_WR_SPL3,
        OP_WR_H_NEG, OP_WR_T_NEG, OP_A_WT_NEG, OP_Z_WR, OP_CP_WRITE,
        OP_MB_W0, OP_MB_W1, OP_WR_IDX,
        OP_A_NEXT, OP_CAP_T, OP_Z_START, OP_CAP_N, OP_CAP_P, OP_MB_LS, OP_CAP_LE,
        OP_C_NEXT, OP_S_ACC, OP_CAP_RD,
        OP_ST_REF, OP_ST_RANGE, OP_ST_COR, OP_PUBLISH
    } dp_op_t;

    typedef enum logic [6:0] {
        S_INIT0, S_INIT1, S_IDLE, S_DISPATCH,
        S_A_START, S_A_RD, S_A_TAG, S_A_STEP, S_A_CAPS,
        S_A_SPL0, S_A_SPL1, S_A_SPL2, S_A_SPL3,
        S_A_CAPN, S_A_NSRD, S_A_NSCMP, S_A_NSW0, S_A_NSW1, S_A_END,
        S_Z_START, S_Z_CHK, S_Z_WR,
        S_RZ_RDOLD, S_RZ_CHKOLD, S_RZ_RDO, S_RZ_RDN, S_RZ_MIN,
        S_CP_CHK, S_CP_RD, S_CP_WR,
        S_R_RDH, S_R_TAG, S_R_CAPT, S_R_RDT, S_R_CMPT, S_R_WH, S_R_WT, S_R_HCHK,
        S_R_RDHM1, S_R_CAPP, S_R_PCHK,
        S_M1_RDP, S_M1_PTAG, S_M1_LS, S_M1_LSCHK, S_M1_RDLS, S_M1_LE, S_M1_LECHK,
        S_M1_W0, S_M1_W1,
        S_M2_RDS, S_M2_LS, S_M2_LSCHK, S_M2_RDLS, S_M2_NTAG, S_M2_LE, S_M2_LECHK,
        S_M2_W0, S_M2_W1,
        S_C_START, S_C_RD, S_C_TAG, S_C_CAPT, S_C_RDT, S_C_CMP, S_C_NEXT,
        S_S_START, S_S_RD, S_S_ACC,
        S_RDW, S_RDCAP, S_WRW, S_RI0, S_RI1,
        S_FAIL_REF, S_FAIL_RANGE, S_FAIL_COR, S_DONE
    } state_t;

    typedef struct packed {
        logic [3:0] cmd;
        logic       words_zero;
        logic       idx_in;
        logic       idxm1_in;
        logic       h_in;
        logic       h_zero;
        logic       u_in;
        logic       ls_in;
        logic       le_in;
        logic       dst_in;
        logic       i_eq_n;
        logic       q_neg;
        logic       q_zero;
        logic       fit;
        logic       split;
        logic       qt_in;
        logic       q_ne_tag;
        logic       lf_neg;
    } dp_status_t;

    function automatic logic in_heap(pos_t x, pos_t n);
        return !x[POS_W-1] && (x < n);
    endfunction

    // magnitude of a tag, 2^31 for the most negative word
    function automatic pos_t room_of(logic [31:0] v);
        logic [31:0] m;
        m = v[31] ? (~v + 32'd1) : v;
        return pos_t'({2'b00, m});
    endfunction

endpackage

`default_nettype wire

### design/boundary_tag_heap_allocator.sv
// Top level of the boundary-tag first-fit heap allocator.
//
// One command transaction on the s_axis channel yields exactly one result
// transaction on the m_axis channel. Commands are taken only while the
// sequencer is idle; a finished result sits in the output register, so the
// next command is accepted while that result still waits for m_axis_tready.
// A new result is not published until the previous one has been taken.
// The time from the accepting edge to m_axis_tvalid depends on the heap
// contents, all through one single-port heap RAM with registered read:
//   alloc walks blocks until the first fit, a zeroed alloc clears each
//   word, resize copies words and then does a release, and check and
//   stats walk the blocks one by one.
// After reset the sequencer writes the two end tags of one free block
// before s_axis_tready first rises; the rest of the heap is undefined
// until written.
`default_nettype none

module boundary_tag_heap_allocator
    import bth_pkg::*;
#(
    parameter int HEAP_WORDS = BTH_HEAP_WORDS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // byte_count[12:0], block_index[23:13], write_value[55:24]
    input  wire logic [55:0] s_axis_tdata,
    // command[3:0]
    input  wire logic [3:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // result_index[10:0], read_value[42:11], words_allocated[53:43],
    // words_available[64:54], blocks_used[74:65], blocks_free[84:75],
    // words_overhead[95:85]
    output logic [95:0]      m_axis_tdata,
    // status[1:0]
    output logic [1:0]       m_axis_tuser
);

    dp_op_t     op;
    dp_status_t stat;

    logic [10:0] result_index, words_allocated, words_available, words_overhead;
    logic [31:0] read_value;
    logic [9:0]  blocks_used, blocks_free;

    bth_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .op        (op),
        .stat      (stat)
    );

    bth_datapath #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_datapath (
        .clk             (clk),
        .op              (op),
        .stat            (stat),
        .command         (s_axis_tuser),
        .byte_count      (s_axis_tdata[12:0]),
        .block_index     (s_axis_tdata[23:13]),
        .write_value     (s_axis_tdata[55:24]),
        .status          (m_axis_tuser),
        .result_index    (result_index),
        .read_value      (read_value),
        .words_allocated (words_allocated),
        .words_available (words_available),
        .blocks_used     (blocks_used),
        .blocks_free     (blocks_free),
        .words_overhead  (words_overhead)
    );

    assign m_axis_tdata = {words_overhead, blocks_free, blocks_used, words_available,
                           words_allocated, read_value, result_index};

endmodule

`default_nettype wire

### design/bth_datapath.sv
// Heap memory, walk registers and result registers of the allocator.
`default_nettype none

module bth_datapath
    import bth_pkg::*;
#(
    parameter int HEAP_WORDS = BTH_HEAP_WORDS
) (
    input  wire logic        clk,
    input  wire dp_op_t      op,
    output dp_status_t       stat,
    input  wire logic [3:0]  command,
    input  wire logic [12:0] byte_count,
    input  wire logic [10:0] block_index,
    input  wire logic [31:0] write_value,
    output logic [1:0]       status,
    output logic [10:0]      result_index,
    output logic [31:0]      read_value,
    output logic [10:0]      words_allocated,
    output logic [10:0]      words_available,
    output logic [9:0]       blocks_used,
    output logic [9:0]       blocks_free,
    output logic [10:0]      words_overhead
);

    localparam int AW = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;
    localparam pos_t NW = pos_t'(HEAP_WORDS);
    localparam logic [31:0] INIT_TAG = 32'(-(HEAP_WORDS - 2));
    localparam pos_t ONE = pos_t'(1);
    localparam pos_t TWO = pos_t'(2);

    logic [31:0] mem [HEAP_WORDS];
    logic [31:0] q_reg;

    logic [3:0]  cmd_reg;
    logic [11:0] words_reg;
    logic [10:0] idx_reg;
    logic [31:0] wv_reg;
    pos_t        h_reg, t_reg, u_reg, ls_reg, le_reg, start_reg, res_reg;
    pos_t        i_reg, n_reg, oldr_reg;
    logic [31:0] tag_reg;
    logic        last_free_reg;
    logic        src_in_reg;
    status_t     st_reg;
    logic [31:0] rd_reg;
    logic [10:0] wa_reg, wv_acc_reg;
    logic [9:0]  bu_reg, bf_reg;

    logic [1:0]  o_st_reg;
    logic [10:0] o_res_reg, o_wa_reg, o_wv_reg, o_wo_reg;
    logic [31:0] o_rd_reg;
    logic [9:0]  o_bu_reg, o_bf_reg;

    pos_t        qroom, tagroom, words_p, idx_p, left, mrg, dst;
    logic        we, re;
    pos_t        addr;
    logic [31:0] wdata;
    logic [13:0] bsum;

    assign bsum    = {1'b0, byte_count} + 14'd3;
    assign qroom   = room_of(q_reg);
    assign tagroom = room_of(tag_reg);
    assign words_p = pos_t'(words_reg);
    assign idx_p   = pos_t'(idx_reg);
    assign left    = tagroom - words_p - TWO;
    assign mrg     = le_reg - u_reg - ONE;
    assign dst     = res_reg + i_reg;

    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.words_zero = (words_reg == 12'd0);
        stat.idx_in     = in_heap(idx_p, NW);
        stat.idxm1_in   = in_heap(idx_p - ONE, NW);
        stat.h_in       = in_heap(h_reg, NW);
        stat.h_zero     = (h_reg == '0);
        stat.u_in       = in_heap(u_reg, NW);
        stat.ls_in      = in_heap(ls_reg, NW);
        stat.le_in      = in_heap(le_reg, NW);
        stat.dst_in     = in_heap(dst, NW);
        stat.i_eq_n     = (i_reg == n_reg);
        stat.q_neg      = q_reg[31];
        stat.q_zero     = (q_reg == 32'd0);
        stat.fit        = q_reg[31] && (words_p <= qroom);
        stat.split      = qroom > (words_p + TWO);
        stat.qt_in      = in_heap(h_reg + qroom + ONE, NW);
        stat.q_ne_tag   = (q_reg != tag_reg);
        stat.lf_neg     = last_free_reg && tag_reg[31];
    end

    always_comb
    begin
        we    = 1'b0;
        re    = 1'b0;
        addr  = '0;
        wdata = 32'd0;
        unique case (op)
            OP_INIT0:      begin we = 1'b1; addr = '0; wdata = INIT_TAG; end
            OP_INIT1:      begin we = 1'b1; addr = NW - ONE; wdata = INIT_TAG; end
            OP_RD_H:       begin re = 1'b1; addr = h_reg; end
            OP_RD_IDXM1:   begin re = 1'b1; addr = idx_p - ONE; end
            OP_RD_T:       begin re = 1'b1; addr = t_reg; end
            OP_RD_HM1:     begin re = 1'b1; addr = h_reg - ONE; end
            OP_RD_U:       begin re = 1'b1; addr = u_reg; end
            OP_RD_LS:      begin re = 1'b1; addr = ls_reg; end
            OP_RD_START:   begin re = 1'b1; addr = start_reg; end
            OP_RD_IDX:     begin re = 1'b1; addr = idx_p; end
            OP_CAP_OLDR:   begin re = 1'b1; addr = res_reg - ONE; end
            OP_CP_READ:    begin re = 1'b1; addr = idx_p + i_reg; end
            OP_WR_H_WORDS: begin we = 1'b1; addr = h_reg; wdata = 32'(words_reg); end
            OP_WR_SPL1:
            begin
                we = 1'b1; addr = h_reg + words_p + ONE; wdata = 32'(words_reg);
            end
            OP_WR_SPL2:
            begin
                we = 1'b1; addr = h_reg + words_p + TWO; wdata = 32'(-left);
            end
            OP_WR_SPL3:    begin we = 1'b1; addr = t_reg; wdata = 32'(-left); end
            OP_WR_H_NEG:   begin we = 1'b1; addr = h_reg; wdata = -tag_reg; end
            OP_WR_T_NEG,
            OP_A_WT_NEG:   begin we = 1'b1; addr = t_reg; wdata = -tag_reg; end
            OP_Z_WR:       begin we = 1'b1; addr = dst; wdata = 32'd0; end
            OP_CP_WRITE:
            begin
                we = 1'b1; addr = dst; wdata = src_in_reg ? q_reg : 32'd0;
            end
            OP_MB_W0:      begin we = 1'b1; addr = u_reg; wdata = 32'(-mrg); end
            OP_MB_W1:      begin we = 1'b1; addr = le_reg; wdata = 32'(-mrg); end
            OP_WR_IDX:     begin we = 1'b1; addr = idx_p; wdata = wv_reg; end
            default:       begin end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr[AW-1:0]] <= wdata;
        end
        if (re)
        begin
            q_reg <= mem[addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_LOAD:
            begin
                cmd_reg    <= command;
                words_reg  <= bsum[13:2];
                idx_reg    <= block_index;
                wv_reg     <= write_value;
                st_reg     <= ST_OK;
                res_reg    <= '0;
                rd_reg     <= 32'd0;
                wa_reg     <= 11'd0;
                wv_acc_reg <= 11'd0;
                bu_reg     <= 10'd0;
                bf_reg     <= 10'd0;
            end
            OP_START:
            begin
                h_reg         <= '0;
                last_free_reg <= 1'b0;
            end
            OP_RD_IDXM1:   h_reg <= idx_p - ONE;
            OP_RD_START:   u_reg <= start_reg;
            OP_CAP_OLDR:   oldr_reg <= qroom;
            OP_CP_READ:    src_in_reg <= in_heap(idx_p + i_reg, NW);
            OP_WR_SPL3:
            begin
                res_reg <= h_reg + ONE;
                n_reg   <= words_p;
            end
            OP_WR_H_NEG:   start_reg <= h_reg;
            OP_A_WT_NEG:
            begin
                res_reg <= h_reg + ONE;
                n_reg   <= tagroom;
            end
            OP_Z_WR,
            OP_CP_WRITE:   i_reg <= i_reg + ONE;
            OP_MB_W0:      start_reg <= u_reg;
            OP_A_NEXT:     h_reg <= h_reg + qroom + TWO;
            OP_CAP_T:
            begin
                tag_reg <= q_reg;
                t_reg   <= h_reg + qroom + ONE;
            end
            OP_Z_START:    i_reg <= '0;
            OP_CAP_N:
            begin
                n_reg <= (oldr_reg < qroom) ? oldr_reg : qroom;
                i_reg <= '0;
            end
            OP_CAP_P:      u_reg <= h_reg - qroom - TWO;
            OP_MB_LS:      ls_reg <= u_reg + qroom + TWO;
            OP_CAP_LE:     le_reg <= ls_reg + qroom + ONE;
            OP_C_NEXT:
            begin
                last_free_reg <= tag_reg[31];
                h_reg         <= t_reg + ONE;
            end
            OP_S_ACC:
            begin
                // a zero tag counts as a free block of no room
                if (!q_reg[31] && (q_reg != 32'd0))
                begin
                    wa_reg <= wa_reg + qroom[10:0];
                    bu_reg <= bu_reg + 10'd1;
                end
                else
                begin
                    wv_acc_reg <= wv_acc_reg + qroom[10:0];
                    bf_reg     <= bf_reg + 10'd1;
                end
                h_reg <= h_reg + qroom + TWO;
            end
            OP_CAP_RD:     rd_reg <= q_reg;
            OP_ST_REF:     st_reg <= ST_REFUSED;
            OP_ST_RANGE:   st_reg <= ST_RANGE;
            OP_ST_COR:     st_reg <= ST_CORRUPT;
            OP_PUBLISH:
            begin
                o_st_reg  <= st_reg;
                o_res_reg <= (st_reg == ST_OK) ? res_reg[10:0] : 11'd0;
                o_rd_reg  <= rd_reg;
                o_wa_reg  <= wa_reg;
                o_wv_reg  <= wv_acc_reg;
                o_bu_reg  <= bu_reg;
                o_bf_reg  <= bf_reg;
                o_wo_reg  <= (cmd_reg == CMD_STATS) ?
                             (11'(HEAP_WORDS) - wa_reg - wv_acc_reg) : 11'd0;
            end
            default:       begin end
        endcase
    end

    assign status          = o_st_reg;
    assign result_index    = o_res_reg;
    assign read_value      = o_rd_reg;
    assign words_allocated = o_wa_reg;
    assign words_available = o_wv_reg;
    assign blocks_used     = o_bu_reg;
    assign blocks_free     = o_bf_reg;
    assign words_overhead  = o_wo_reg;

endmodule

`default_nettype wire

### design/bth_ctrl.sv
// Command sequencer of the allocator: walks, merges, copies and handshakes.
`default_nettype none

module bth_ctrl
    import bth_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    output dp_op_t          op,
    input  wire dp_status_t stat
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    state_t fail_rel;

    assign out_free = !out_valid_reg || out_ready;
    // release errors inside a resize all read as a refusal
    assign fail_rel = (stat.cmd == CMD_RESIZE) ? S_FAIL_REF : S_FAIL_COR;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT0:    state_next = S_INIT1;
            S_INIT1:    state_next = S_IDLE;
            S_IDLE:     if (in_valid) state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                unique case (stat.cmd)
                    CMD_ALLOC,
                    CMD_ALLOC_ZEROED:
                        state_next = stat.words_zero ? S_FAIL_REF : S_A_START;
                    CMD_RESIZE:
                        state_next = stat.idxm1_in ? S_RZ_RDOLD : S_FAIL_REF;
                    CMD_RELEASE:
                        state_next = stat.idxm1_in ? S_R_RDH : S_FAIL_RANGE;
                    CMD_CHECK:      state_next = S_C_START;
                    CMD_STATS:      state_next = S_S_START;
                    CMD_READ_WORD:  state_next = stat.idx_in ? S_RDW : S_FAIL_RANGE;
                    CMD_WRITE_WORD: state_next = stat.idx_in ? S_WRW : S_FAIL_RANGE;
                    CMD_REINIT:     state_next = S_RI0;
                    default:        state_next = S_FAIL_REF;
                endcase
            end
            S_A_START:  state_next = S_A_RD;
            S_A_RD:     state_next = stat.h_in ? S_A_TAG : S_FAIL_REF;
            S_A_TAG:
            begin
                priority if (!stat.fit)    state_next = S_A_STEP;
                else if (!stat.qt_in)      state_next = S_FAIL_REF;
                else if (stat.split)       state_next = S_A_CAPS;
                else                       state_next = S_A_CAPN;
            end
            S_A_STEP:   state_next = S_A_RD;
            S_A_CAPS:   state_next = S_A_SPL0;
            S_A_SPL0:   state_next = S_A_SPL1;
            S_A_SPL1:   state_next = S_A_SPL2;
            S_A_SPL2:   state_next = S_A_SPL3;
            S_A_SPL3:   state_next = S_A_END;
            S_A_CAPN:   state_next = S_A_NSRD;
            S_A_NSRD:   state_next = S_A_NSCMP;
            S_A_NSCMP:  state_next = stat.q_ne_tag ? S_FAIL_REF : S_A_NSW0;
            S_A_NSW0:   state_next = S_A_NSW1;
            S_A_NSW1:   state_next = S_A_END;
            S_A_END:
            begin
                priority if (stat.cmd == CMD_ALLOC_ZEROED) state_next = S_Z_START;
                else if (stat.cmd == CMD_RESIZE)          state_next = S_RZ_RDO;
                else                                      state_next = S_DONE;
            end
            S_Z_START:  state_next = S_Z_CHK;
            S_Z_CHK:    state_next = stat.i_eq_n ? S_DONE : S_Z_WR;
            S_Z_WR:     state_next = S_Z_CHK;
            S_RZ_RDOLD: state_next = S_RZ_CHKOLD;
            S_RZ_CHKOLD:
                state_next = (stat.q_neg || stat.words_zero) ? S_FAIL_REF : S_A_START;
            S_RZ_RDO:   state_next = S_RZ_RDN;
            S_RZ_RDN:   state_next = S_RZ_MIN;
            S_RZ_MIN:   state_next = S_CP_CHK;
            // past the heap end no destination word is ever written again
            S_CP_CHK:   state_next = (stat.i_eq_n || !stat.dst_in) ? S_R_RDH : S_CP_RD;
            S_CP_RD:    state_next = S_CP_WR;
            S_CP_WR:    state_next = S_CP_CHK;
            S_R_RDH:    state_next = S_R_TAG;
            S_R_TAG:
            begin
                priority if (stat.q_neg)  state_next = fail_rel;
                else if (!stat.qt_in)     state_next = fail_rel;
                else                      state_next = S_R_CAPT;
            end
            S_R_CAPT:   state_next = S_R_RDT;
            S_R_RDT:    state_next = S_R_CMPT;
            S_R_CMPT:   state_next = stat.q_ne_tag ? fail_rel : S_R_WH;
            S_R_WH:     state_next = S_R_WT;
            S_R_WT:     state_next = S_R_HCHK;
            S_R_HCHK:   state_next = stat.h_zero ? S_M2_RDS : S_R_RDHM1;
            S_R_RDHM1:  state_next = S_R_CAPP;
            S_R_CAPP:   state_next = S_R_PCHK;
            S_R_PCHK:   state_next = stat.u_in ? S_M1_RDP : S_M2_RDS;
            S_M1_RDP:   state_next = S_M1_PTAG;
            S_M1_PTAG:  state_next = stat.q_neg ? S_M1_LS : S_M2_RDS;
            S_M1_LS:    state_next = S_M1_LSCHK;
            S_M1_LSCHK: state_next = stat.ls_in ? S_M1_RDLS : S_M2_RDS;
            S_M1_RDLS:  state_next = S_M1_LE;
            S_M1_LE:    state_next = S_M1_LECHK;
            S_M1_LECHK: state_next = stat.le_in ? S_M1_W0 : S_M2_RDS;
            S_M1_W0:    state_next = S_M1_W1;
            S_M1_W1:    state_next = S_M2_RDS;
            S_M2_RDS:   state_next = S_M2_LS;
            S_M2_LS:    state_next = S_M2_LSCHK;
            S_M2_LSCHK: state_next = stat.ls_in ? S_M2_RDLS : S_DONE;
            S_M2_RDLS:  state_next = S_M2_NTAG;
            S_M2_NTAG:  state_next = stat.q_neg ? S_M2_LE : S_DONE;
            S_M2_LE:    state_next = S_M2_LECHK;
            S_M2_LECHK: state_next = stat.le_in ? S_M2_W0 : S_DONE;
            S_M2_W0:    state_next = S_M2_W1;
            S_M2_W1:    state_next = S_DONE;
            S_C_START:  state_next = S_C_RD;
            S_C_RD:     state_next = stat.h_in ? S_C_TAG : S_DONE;
            S_C_TAG:
                state_next = (stat.q_zero || !stat.qt_in) ? S_FAIL_COR : S_C_CAPT;
            S_C_CAPT:   state_next = S_C_RDT;
            S_C_RDT:    state_next = S_C_CMP;
            S_C_CMP:
                state_next = (stat.q_ne_tag || stat.lf_neg) ? S_FAIL_COR : S_C_NEXT;
            S_C_NEXT:   state_next = S_C_RD;
            S_S_START:  state_next = S_S_RD;
            S_S_RD:     state_next = stat.h_in ? S_S_ACC : S_DONE;
            S_S_ACC:    state_next = S_S_RD;
            S_RDW:      state_next = S_RDCAP;
            S_RDCAP:    state_next = S_DONE;
            S_WRW:      state_next = S_DONE;
            S_RI0:      state_next = S_RI1;
            S_RI1:      state_next = S_DONE;
            S_FAIL_REF,
            S_FAIL_RANGE,
            S_FAIL_COR: state_next = S_DONE;
            S_DONE:     if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op = OP_NOP;
        unique case (state_reg)
            S_INIT0, S_RI0:           op = OP_INIT0;
            S_INIT1, S_RI1:           op = OP_INIT1;
            S_IDLE:                   op = in_valid ? OP_LOAD : OP_NOP;
            S_A_START, S_C_START,
            S_S_START:                op = OP_START;
            S_A_RD, S_C_RD, S_S_RD:   op = OP_RD_H;
            S_A_STEP:                 op = OP_A_NEXT;
            S_A_CAPS, S_A_CAPN,
            S_R_CAPT, S_C_CAPT:       op = OP_CAP_T;
            S_A_SPL0:                 op = OP_WR_H_WORDS;
            S_A_SPL1:                 op = OP_WR_SPL1;
            S_A_SPL2:                 op = OP_WR_SPL2;
            S_A_SPL3:                 op = OP_WR_SPL3;
            S_A_NSRD, S_R_RDT,
            S_C_RDT:                  op = OP_RD_T;
            S_A_NSW0, S_R_WH:         op = OP_WR_H_NEG;
            S_A_NSW1:                 op = OP_A_WT_NEG;
            S_Z_START:                op = OP_Z_START;
            S_Z_WR:                   op = OP_Z_WR;
            S_RZ_RDOLD, S_RZ_RDO,
            S_R_RDH:                  op = OP_RD_IDXM1;
            S_RZ_RDN:                 op = OP_CAP_OLDR;
            S_RZ_MIN:                 op = OP_CAP_N;
            S_CP_RD:                  op = OP_CP_READ;
            S_CP_WR:                  op = OP_CP_WRITE;
            S_R_WT:                   op = OP_WR_T_NEG;
            S_R_RDHM1:                op = OP_RD_HM1;
            S_R_CAPP:                 op = OP_CAP_P;
            S_M1_RDP:                 op = OP_RD_U;
            S_M1_LS, S_M2_LS:         op = OP_MB_LS;
            S_M1_RDLS, S_M2_RDLS:     op = OP_RD_LS;
            S_M1_LE, S_M2_LE:         op = OP_CAP_LE;
            S_M1_W0, S_M2_W0:         op = OP_MB_W0;
            S_M1_W1, S_M2_W1:         op = OP_MB_W1;
            S_M2_RDS:                 op = OP_RD_START;
            S_C_NEXT:                 op = OP_C_NEXT;
            S_S_ACC:                  op = OP_S_ACC;
            S_RDW:                    op = OP_RD_IDX;
            S_RDCAP:                  op = OP_CAP_RD;
            S_WRW:                    op = OP_WR_IDX;
            S_FAIL_REF:               op = OP_ST_REF;
            S_FAIL_RANGE:             op = OP_ST_RANGE;
            S_FAIL_COR:               op = OP_ST_COR;
            S_DONE:                   op = out_free ? OP_PUBLISH : OP_NOP;
            default:                  op = OP_NOP;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((state_reg == S_DONE) && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire
